[sv/tgc_pkg.sv]
`default_nettype none
package tgc_pkg;

   // Default geometry of the block.
   localparam int DEF_COORD_BITS = 12;
   localparam int DEF_TIME_BITS  = 32;

   // Widths of the configuration registers and of the port.
   localparam int SCREEN_W   = 12;
   localparam int CLICK_W    = 16;
   localparam int MOVE_W     = 12;
   localparam int RELEASE_W  = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int SPEED_W    = 8;

   // Reset values of the configuration registers.
   localparam logic [SCREEN_W-1:0]  RST_SCREEN_WIDTH  = 12'd800;
   localparam logic [SCREEN_W-1:0]  RST_SCREEN_HEIGHT = 12'd1280;
   localparam logic [CLICK_W-1:0]   RST_CLICK_TIME    = 16'd200;
   localparam logic [MOVE_W-1:0]    RST_MOVE_DISTANCE = 12'd50;
   localparam logic [RELEASE_W-1:0] RST_RELEASE_DELAY = 16'd100;

   localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

   // Register indexes, taken from the word address of the port.
   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_CLICK_TIME    = 3'd2,
      REG_MOVE_DISTANCE = 3'd3,
      REG_RELEASE_DELAY = 3'd4
   } reg_index_type;

   // Item kinds on the request channel.
   localparam logic [1:0] MODE_CONTACT = 2'd0;
   localparam logic [1:0] MODE_POLL    = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

[sv/tgc_req_if.sv]
`default_nettype none
interface tgc_req_if
   import tgc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int TIME_BITS  = DEF_TIME_BITS
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            mode;
   logic [COORD_BITS-1:0] touch_x;
   logic [COORD_BITS-1:0] touch_y;
   logic [TIME_BITS-1:0]  now_ms;

   modport source (output valid, mode, touch_x, touch_y, now_ms, input ready);
   modport sink (input valid, mode, touch_x, touch_y, now_ms, output ready);
endinterface
`default_nettype wire

[sv/tgc_rsp_if.sv]
`default_nettype none
interface tgc_rsp_if
   import tgc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
);
   logic                  valid;
   logic                  ready;
   logic                  is_click;
   logic                  swipe_up;
   logic                  swipe_down;
   logic                  swipe_left;
   logic                  swipe_right;
   logic [SPEED_W-1:0]    speed_vertical;
   logic [SPEED_W-1:0]    speed_horizontal;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (output valid, is_click, swipe_up, swipe_down, swipe_left,
                   swipe_right, speed_vertical, speed_horizontal, end_x, end_y,
                   input ready);
   modport sink (input valid, is_click, swipe_up, swipe_down, swipe_left,
                 swipe_right, speed_vertical, speed_horizontal, end_x, end_y,
                 output ready);
endinterface
`default_nettype wire

[sv/tgc_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module tgc_divider
   import tgc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int TIME_BITS  = DEF_TIME_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COORD_BITS-1:0] dividend,
   input  wire logic [TIME_BITS-1:0]  divisor,
   output      div_status_type        status,
   output      logic [COORD_BITS-1:0] quotient
);
   localparam int CNT_W = $clog2(COORD_BITS + 1);

   logic [TIME_BITS-1:0]  rem_ff;
   logic [TIME_BITS-1:0]  rem_in;
   logic [COORD_BITS-1:0] quo_ff;
   logic [TIME_BITS-1:0]  dvs_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [TIME_BITS:0]    shifted;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[COORD_BITS-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      rem_in  = fits ? TIME_BITS'(shifted - {1'b0, dvs_ff})
                     : shifted[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(COORD_BITS);
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[COORD_BITS-2:0], fits};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
endmodule
`default_nettype wire

[sv/touch_gesture_classifier.sv]
// Touch gesture classifier.
// Items arrive on the req channel: a contact sample, a poll without contact,
// or an explicit release, each stamped with a millisecond time. A gesture
// ends on a release, or on a poll once the release delay has passed since
// the last contact, and each end sends one transfer on the rsp channel.
// A contact sample or an item that ends nothing only passes through capture
// and evaluation. For an item that ends a gesture, the speeds of the axes
// that swiped are computed one after the other by a single restoring
// divider that retires one quotient bit per cycle. req.ready is high only
// while the sequencer is idle. The result sits in an output register, so the
// block takes the next item while a finished result still waits; if the
// receiver stalls and another gesture ends, that second result waits in the
// sequencer until the output register frees up. Synchronous reset clears the
// gesture state, drops any pending result and loads the register defaults.
// The APB-style port writes registers at word addresses; reads return them.
`default_nettype none
module touch_gesture_classifier
   import tgc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int TIME_BITS  = DEF_TIME_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tgc_req_if.sink                    req,
   tgc_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);
   // Common width for comparing coordinates against 12-bit registers.
   localparam int CMP_W = (COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_Y,
      ST_WAIT_Y,
      ST_DIV_X,
      ST_WAIT_X,
      ST_EMIT
   } state_type;

   // Configuration registers.
   logic [SCREEN_W-1:0]  screen_width_ff;
   logic [SCREEN_W-1:0]  screen_height_ff;
   logic [CLICK_W-1:0]   click_time_ff;
   logic [MOVE_W-1:0]    move_distance_ff;
   logic [RELEASE_W-1:0] release_delay_ff;

   // Captured request item.
   logic [1:0]            mode_ff;
   logic [COORD_BITS-1:0] touch_x_ff;
   logic [COORD_BITS-1:0] touch_y_ff;
   logic [TIME_BITS-1:0]  now_ff;

   // Gesture state.
   state_type             state_ff;
   logic                  open_ff;
   logic [TIME_BITS-1:0]  start_time_ff;
   logic [TIME_BITS-1:0]  last_contact_ff;
   logic [COORD_BITS-1:0] start_x_ff;
   logic [COORD_BITS-1:0] start_y_ff;
   logic [COORD_BITS-1:0] last_x_ff;
   logic [COORD_BITS-1:0] last_y_ff;

   // Results of the evaluation step.
   logic [TIME_BITS-1:0]  dur_ff;
   logic [COORD_BITS-1:0] dist_x_ff;
   logic [COORD_BITS-1:0] dist_y_ff;
   logic                  click_ff;
   logic                  up_ff;
   logic                  down_ff;
   logic                  left_ff;
   logic                  right_ff;
   logic [SPEED_W-1:0]    speed_v_ff;
   logic [SPEED_W-1:0]    speed_h_ff;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_click_ff;
   logic                  rsp_up_ff;
   logic                  rsp_down_ff;
   logic                  rsp_left_ff;
   logic                  rsp_right_ff;
   logic [SPEED_W-1:0]    rsp_speed_v_ff;
   logic [SPEED_W-1:0]    rsp_speed_h_ff;
   logic [COORD_BITS-1:0] rsp_end_x_ff;
   logic [COORD_BITS-1:0] rsp_end_y_ff;

   // Evaluation terms, all taken from registered values.
   logic [TIME_BITS-1:0]  dur_in;
   logic [TIME_BITS-1:0]  idle_time;
   logic                  timed_out;
   logic                  ends_gesture;
   logic                  click_in;
   logic                  low_x;
   logic                  low_y;
   logic [COORD_BITS-1:0] dist_x_in;
   logic [COORD_BITS-1:0] dist_y_in;
   logic                  swipe_x;
   logic                  swipe_y;

   // Divider hookup.
   logic                  div_start;
   logic [COORD_BITS-1:0] div_dividend;
   div_status_type        div_status;
   logic [COORD_BITS-1:0] div_quotient;
   logic [SPEED_W-1:0]    speed_sat;

   logic                  csr_write;
   reg_index_type         csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RST_SCREEN_WIDTH;
         screen_height_ff <= RST_SCREEN_HEIGHT;
         click_time_ff    <= RST_CLICK_TIME;
         move_distance_ff <= RST_MOVE_DISTANCE;
         release_delay_ff <= RST_RELEASE_DELAY;
      end else if (csr_write) begin
         // Writes to indexes beyond the register list fall through the case.
         case (csr_index)
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_pwdata[SCREEN_W-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_pwdata[SCREEN_W-1:0];
            REG_CLICK_TIME:    click_time_ff    <= csr_pwdata[CLICK_W-1:0];
            REG_MOVE_DISTANCE: move_distance_ff <= csr_pwdata[MOVE_W-1:0];
            REG_RELEASE_DELAY: release_delay_ff <= csr_pwdata[RELEASE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_W'(screen_width_ff);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_W'(screen_height_ff);
         REG_CLICK_TIME:    csr_prdata = CSR_DATA_W'(click_time_ff);
         REG_MOVE_DISTANCE: csr_prdata = CSR_DATA_W'(move_distance_ff);
         REG_RELEASE_DELAY: csr_prdata = CSR_DATA_W'(release_delay_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Both time differences wrap modulo the timestamp width. An axis moves
   // toward its low end when its start coordinate lies above its end.
   always_comb begin
      dur_in       = now_ff - start_time_ff;
      idle_time    = now_ff - last_contact_ff;
      timed_out    = idle_time > TIME_BITS'(release_delay_ff);
      ends_gesture = open_ff && ((mode_ff == MODE_RELEASE) ||
                                 ((mode_ff == MODE_POLL) && timed_out));
      click_in     = dur_in < TIME_BITS'(click_time_ff);
      low_x        = start_x_ff > last_x_ff;
      low_y        = start_y_ff > last_y_ff;
      dist_x_in    = low_x ? (start_x_ff - last_x_ff) : (last_x_ff - start_x_ff);
      dist_y_in    = low_y ? (start_y_ff - last_y_ff) : (last_y_ff - start_y_ff);
      swipe_x      = CMP_W'(dist_x_in) > CMP_W'(move_distance_ff);
      swipe_y      = CMP_W'(dist_y_in) > CMP_W'(move_distance_ff);
   end

   // The divider runs only for an axis that actually swiped. A zero
   // duration gives an all-ones quotient, which saturates like any other
   // oversized speed.
   assign div_start    = ((state_ff == ST_DIV_Y) && (up_ff || down_ff)) ||
                         ((state_ff == ST_DIV_X) && (left_ff || right_ff));
   assign div_dividend = (state_ff == ST_DIV_Y) ? dist_y_ff : dist_x_ff;
   assign speed_sat    = (div_quotient > COORD_BITS'(SPEED_MAX)) ? SPEED_MAX
                                                                : div_quotient[SPEED_W-1:0];

   tgc_divider #(
      .COORD_BITS (COORD_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dur_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         open_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         start_time_ff   <= '0;
         last_contact_ff <= '0;
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
      end else begin
         // While a result waits to be handed over, the emit step below decides
         // what the output register holds next.
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  mode_ff    <= req.mode;
                  touch_x_ff <= req.touch_x;
                  touch_y_ff <= req.touch_y;
                  now_ff     <= req.now_ms;
                  state_ff   <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               state_ff <= ST_IDLE;
               if (mode_ff == MODE_CONTACT) begin
                  last_contact_ff <= now_ff;
                  if (!open_ff) begin
                     open_ff       <= 1'b1;
                     start_time_ff <= now_ff;
                     start_x_ff    <= touch_x_ff;
                     start_y_ff    <= touch_y_ff;
                  end
                  // Points off the screen do not move the end point.
                  if (CMP_W'(touch_x_ff) < CMP_W'(screen_width_ff)) begin
                     last_x_ff <= touch_x_ff;
                  end
                  if (CMP_W'(touch_y_ff) < CMP_W'(screen_height_ff)) begin
                     last_y_ff <= touch_y_ff;
                  end
               end else if (ends_gesture) begin
                  open_ff    <= 1'b0;
                  dur_ff     <= dur_in;
                  dist_x_ff  <= dist_x_in;
                  dist_y_ff  <= dist_y_in;
                  click_ff   <= click_in;
                  up_ff      <= !click_in && swipe_y && low_y;
                  down_ff    <= !click_in && swipe_y && !low_y;
                  left_ff    <= !click_in && swipe_x && low_x;
                  right_ff   <= !click_in && swipe_x && !low_x;
                  speed_v_ff <= '0;
                  speed_h_ff <= '0;
                  state_ff   <= ST_DIV_Y;
               end
            end
            ST_DIV_Y: begin
               state_ff <= (up_ff || down_ff) ? ST_WAIT_Y : ST_DIV_X;
            end
            ST_WAIT_Y: begin
               if (div_status.done) begin
                  speed_v_ff <= speed_sat;
                  state_ff   <= ST_DIV_X;
               end
            end
            ST_DIV_X: begin
               state_ff <= (left_ff || right_ff) ? ST_WAIT_X : ST_EMIT;
            end
            ST_WAIT_X: begin
               if (div_status.done) begin
                  speed_h_ff <= speed_sat;
                  state_ff   <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // Hand the result over once the output register is free or
               // is being emptied in this cycle.
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_click_ff   <= click_ff;
                  rsp_up_ff      <= up_ff;
                  rsp_down_ff    <= down_ff;
                  rsp_left_ff    <= left_ff;
                  rsp_right_ff   <= right_ff;
                  rsp_speed_v_ff <= speed_v_ff;
                  rsp_speed_h_ff <= speed_h_ff;
                  rsp_end_x_ff   <= last_x_ff;
                  rsp_end_y_ff   <= last_y_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready            = (state_ff == ST_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.is_click         = rsp_click_ff;
   assign rsp.swipe_up         = rsp_up_ff;
   assign rsp.swipe_down       = rsp_down_ff;
   assign rsp.swipe_left       = rsp_left_ff;
   assign rsp.swipe_right      = rsp_right_ff;
   assign rsp.speed_vertical   = rsp_speed_v_ff;
   assign rsp.speed_horizontal = rsp_speed_h_ff;
   assign rsp.end_x            = rsp_end_x_ff;
   assign rsp.end_y            = rsp_end_y_ff;
endmodule
`default_nettype wire
